>>> design/sorted_key_bound_search_macros.svh
// assertion macros for sorted_key_bound_search
`ifndef SORTED_KEY_BOUND_SEARCH_MACROS_SVH
`define SORTED_KEY_BOUND_SEARCH_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SKBS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("skbs assertion failed");

// next-cycle implication
`define SKBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("skbs assertion failed");

`else

`define SKBS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SKBS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> design/skbs_pkg.sv
package skbs_pkg;

  localparam int WORD_W   = 32;
  localparam int RESULT_W = 10;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [2:0] OP_LT = 3'd0;
  localparam logic [2:0] OP_LE = 3'd1;
  localparam logic [2:0] OP_EQ = 3'd2;
  localparam logic [2:0] OP_GT = 3'd3;
  localparam logic [2:0] OP_GE = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP
  } state_t;

  typedef struct packed {
    logic lt;
    logic gt;
  } order_t;

endpackage

>>> design/sorted_key_bound_search.sv
// query: each probe passes ST_PROBE, which reads one key, then ST_CMP; the result strobe is
//   registered from the final ST_PROBE, or from ST_CMP on an equal match; p probes, p <= floor(log2(entry count))+1
// busy is high while a search runs and is low again when the result strobe shows
// clear and append do not raise busy; bad compare op answers next cycle
// results cannot be stalled: out_valid is a one-cycle strobe
// synchronous active-low reset clears entry count, state and sets key words in use to 1
`include "sorted_key_bound_search_macros.svh"

module sorted_key_bound_search #(
  parameter int CAPACITY  = 256,
  parameter int KEY_WORDS = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [1:0]                           in_req_type,
  input  logic signed [skbs_pkg::WORD_W-1:0]   in_key_word_first,
  input  logic signed [skbs_pkg::WORD_W-1:0]   in_key_word_second,
  input  logic [2:0]                           in_compare_op,
  output logic                                 out_valid,
  output logic signed [skbs_pkg::RESULT_W-1:0] out_result_index,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);
  localparam int WW = skbs_pkg::WORD_W;
  localparam int KW = WW * KEY_WORDS;

  skbs_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]        count_r, count_nxt;
  logic [1:0]           words_r;
  logic signed [CW:0]   lo_r, lo_nxt, hi_r, hi_nxt, ans_r, ans_nxt, mid_r, mid_nxt;
  logic signed [WW-1:0] q_first_r, q_first_nxt, q_second_r, q_second_nxt;
  logic [2:0]           op_r, op_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [skbs_pkg::RESULT_W-1:0] out_index_r, out_index_nxt;

  logic                 wr_en, rd_en, full, lo_le_hi, two_words;
  logic [KW-1:0]        wr_data, rd_data_r;
  logic [KW-1:0]        key_mem [CAPACITY];
  logic signed [CW+1:0] mid_sum;
  logic signed [CW:0]   mid, count_s, fin_val;
  logic signed [31:0]   fin_ext;
  skbs_pkg::order_t     order;

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != skbs_pkg::ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;

  assign full      = (count_r == CW'(CAPACITY));
  assign count_s   = signed'({1'b0, count_r});
  assign two_words = (KEY_WORDS >= 2) && (words_r >= 2'd2);
  assign lo_le_hi  = (lo_r <= hi_r);
  assign mid_sum   = {lo_r[CW], lo_r} + {hi_r[CW], hi_r};
  assign mid       = mid_sum[CW+1:1];
  assign wr_data   = KW'({in_key_word_first, in_key_word_second} >> (2 * WW - KW));
  assign rd_en     = (state_r == skbs_pkg::ST_PROBE) && lo_le_hi;
  assign fin_ext   = 32'(fin_val);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[count_r[IW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= key_mem[mid[IW-1:0]];
    end
  end

  skbs_key_cmp u_cmp (
    .entry_first  (signed'(rd_data_r[KW-1 -: WW])),
    .entry_second (signed'(rd_data_r[WW-1:0])),
    .key_first    (q_first_r),
    .key_second   (q_second_r),
    .two_words    (two_words),
    .order        (order)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skbs_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      words_r     <= 2'd1;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        words_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    ans_r       <= ans_nxt;
    mid_r       <= mid_nxt;
    q_first_r   <= q_first_nxt;
    q_second_r  <= q_second_nxt;
    op_r        <= op_nxt;
    out_index_r <= out_index_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    ans_nxt       = ans_r;
    mid_nxt       = mid_r;
    q_first_nxt   = q_first_r;
    q_second_nxt  = q_second_r;
    op_nxt        = op_r;
    out_valid_nxt = 1'b0;
    out_index_nxt = out_index_r;
    wr_en         = 1'b0;
    fin_val       = ans_r;
    case (state_r)
      skbs_pkg::ST_IDLE: begin
        if (start) begin
          case (in_req_type)
            skbs_pkg::REQ_CLEAR: begin
              count_nxt = '0;
            end
            skbs_pkg::REQ_APPEND: begin
              if (!full) begin
                wr_en     = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            skbs_pkg::REQ_QUERY: begin
              q_first_nxt  = in_key_word_first;
              q_second_nxt = in_key_word_second;
              op_nxt       = in_compare_op;
              if (in_compare_op > skbs_pkg::OP_GE) begin
                fin_val       = '1;
                out_valid_nxt = 1'b1;
                out_index_nxt = fin_ext[skbs_pkg::RESULT_W-1:0];
              end else begin
                lo_nxt = '0;
                hi_nxt = count_s - (CW+1)'(1);
                if (in_compare_op inside {skbs_pkg::OP_LT, skbs_pkg::OP_LE, skbs_pkg::OP_EQ}) begin
                  ans_nxt = '1;
                end else begin
                  ans_nxt = count_s;
                end
                state_nxt = skbs_pkg::ST_PROBE;
              end
            end
            default: begin
            end
          endcase
        end
      end
      skbs_pkg::ST_PROBE: begin
        if (lo_le_hi) begin
          mid_nxt   = mid;
          state_nxt = skbs_pkg::ST_CMP;
        end else begin
          fin_val       = ans_r;
          out_valid_nxt = 1'b1;
          out_index_nxt = fin_ext[skbs_pkg::RESULT_W-1:0];
          state_nxt     = skbs_pkg::ST_IDLE;
        end
      end
      skbs_pkg::ST_CMP: begin
        state_nxt = skbs_pkg::ST_PROBE;
        if (order.lt) begin
          lo_nxt = mid_r + (CW+1)'(1);
          if (op_r inside {skbs_pkg::OP_LT, skbs_pkg::OP_LE}) begin
            ans_nxt = mid_r;
          end
        end else if (order.gt) begin
          hi_nxt = mid_r - (CW+1)'(1);
          if (op_r inside {skbs_pkg::OP_GT, skbs_pkg::OP_GE}) begin
            ans_nxt = mid_r;
          end
        end else begin
          case (op_r)
            skbs_pkg::OP_EQ: begin
              fin_val       = mid_r;
              out_valid_nxt = 1'b1;
              out_index_nxt = fin_ext[skbs_pkg::RESULT_W-1:0];
              state_nxt     = skbs_pkg::ST_IDLE;
            end
            skbs_pkg::OP_LT: begin
              hi_nxt = mid_r - (CW+1)'(1);
            end
            skbs_pkg::OP_GT: begin
              lo_nxt = mid_r + (CW+1)'(1);
            end
            skbs_pkg::OP_LE: begin
              lo_nxt  = mid_r + (CW+1)'(1);
              ans_nxt = mid_r;
            end
            default: begin
              hi_nxt  = mid_r - (CW+1)'(1);
              ans_nxt = mid_r;
            end
          endcase
        end
      end
      default: begin
        state_nxt = skbs_pkg::ST_IDLE;
      end
    endcase
  end

  // a result strobe always comes with the block back in idle
  `SKBS_ASSERT_NOW(a_out_idle, clk, rst_n, out_valid, !busy)
  // entry count never passes capacity
  `SKBS_ASSERT_NOW(a_count_cap, clk, rst_n, 1'b1, count_r <= CW'(CAPACITY))
  // an open probe window always goes to a compare step
  `SKBS_ASSERT_NEXT(a_probe_cmp, clk, rst_n, rd_en, state_r == skbs_pkg::ST_CMP)
  // a query transfer either starts a search or answers at once
  `SKBS_ASSERT_NEXT(a_query_go, clk, rst_n,
    start && !busy && (in_req_type == skbs_pkg::REQ_QUERY), busy || out_valid)

endmodule

>>> design/skbs_key_cmp.sv
module skbs_key_cmp (
  input  logic signed [skbs_pkg::WORD_W-1:0] entry_first,
  input  logic signed [skbs_pkg::WORD_W-1:0] entry_second,
  input  logic signed [skbs_pkg::WORD_W-1:0] key_first,
  input  logic signed [skbs_pkg::WORD_W-1:0] key_second,
  input  logic                               two_words,
  output skbs_pkg::order_t                   order
);

  logic first_lt, first_gt, second_lt, second_gt;

  assign first_lt  = entry_first < key_first;
  assign first_gt  = entry_first > key_first;
  assign second_lt = entry_second < key_second;
  assign second_gt = entry_second > key_second;

  // lexicographic, most significant word first
  always_comb begin
    order.lt = first_lt;
    order.gt = first_gt;
    if (!first_lt && !first_gt && two_words) begin
      order.lt = second_lt;
      order.gt = second_gt;
    end
  end

endmodule
